/* sv/hpm_pkg.sv */
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared widths, register codes and pipeline item types of the point mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package hpm_pkg;

    localparam int PIXEL_BITS  = 16;
    localparam int COEF_W      = 32;
    localparam int NUM_REGS    = 8;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int ADDR_W      = $clog2(NUM_REGS * 4);
    localparam int IN_DATA_W   = ((2 * PIXEL_BITS + 7) / 8) * 8;
    localparam int QUOT_W      = 32;
    localparam int OUT_DATA_W  = 2 * QUOT_W;

    // coefficient times zero-extended pixel
    localparam int PROD_W      = COEF_W + PIXEL_BITS + 1;
    // two products plus offset or the constant one
    localparam int SUM_W       = PROD_W + 1;
    localparam int MAG_W       = SUM_W;

    localparam int OFFSET_SHIFT = 4;
    localparam int ONE_SHIFT    = 34;
    localparam int FEED_W       = 2;

    localparam logic signed [SUM_W-1:0] W_ONE = SUM_W'(1) <<< ONE_SHIFT;

    localparam logic [QUOT_W-1:0] POS_LIMIT = {1'b0, {(QUOT_W - 1){1'b1}}};
    localparam logic [QUOT_W-1:0] NEG_LIMIT = {1'b1, {(QUOT_W - 1){1'b0}}};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_XX = 3'd0,
        REG_COEF_XY = 3'd1,
        REG_COEF_XO = 3'd2,
        REG_COEF_YX = 3'd3,
        REG_COEF_YY = 3'd4,
        REG_COEF_YO = 3'd5,
        REG_PERSP_X = 3'd6,
        REG_PERSP_Y = 3'd7
    } hpm_reg_t;

    localparam logic [COEF_W-1:0] COEF_RESET [NUM_REGS] = '{
        32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0
    };

    // one division lane: partial remainder, numerator bits still to shift in,
    // quotient so far and the flags that decide the final value
    typedef struct packed {
        logic [MAG_W-1:0]  rem;
        logic [FEED_W-1:0] feed;
        logic [QUOT_W-1:0] quo;
        logic              neg;
        logic              sat;
        logic              zero;
    } hpm_lane_t;

    typedef struct packed {
        logic [MAG_W-1:0] den;
        hpm_lane_t        lx;
        hpm_lane_t        ly;
    } hpm_div_t;

endpackage

`default_nettype wire

/* sv/hpm_div_step.sv */
// ----------------------------------------------------------------------------
// hpm_div_step
// One registered restoring-division step: one quotient bit for each lane.
// ----------------------------------------------------------------------------
`default_nettype none

module hpm_div_step
    import hpm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_vld,
    input  wire hpm_div_t in_item,
    output logic          out_vld,
    output hpm_div_t      out_item
);

    function automatic hpm_lane_t step_lane(input hpm_lane_t l, input logic [MAG_W-1:0] den);
        logic [MAG_W:0] trial;
        logic           take;
        hpm_lane_t      r;
        trial  = {l.rem, l.feed[FEED_W-1]};
        take   = (trial >= {1'b0, den});
        r      = l;
        r.rem  = take ? MAG_W'(trial - {1'b0, den}) : trial[MAG_W-1:0];
        r.feed = {l.feed[FEED_W-2:0], 1'b0};
        r.quo  = {l.quo[QUOT_W-2:0], take};
        return r;
    endfunction

    logic     vld_reg;
    hpm_div_t item_reg;
    hpm_div_t item_next;

    always_comb
    begin
        item_next     = in_item;
        item_next.lx  = step_lane(in_item.lx, in_item.den);
        item_next.ly  = step_lane(in_item.ly, in_item.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

`default_nettype wire

/* sv/homography_point_map_top.sv */
// ----------------------------------------------------------------------------
// homography_point_map_top
// Maps Q12.4 points through a 3x3 perspective matrix to Q16.16, saturating.
// ----------------------------------------------------------------------------
//  channel     direction  fields
//  s_axis      in         tdata: pixel_x, pixel_y
//  m_axis      out        tdata: mapped_x, mapped_y; tuser: bad_result
//  apb         in/out     eight 32-bit matrix registers at byte address 4*i
//
//  one item per cycle unless a stalled output holds the pipeline; stages: multiply,
//  sum, magnitude, range check, 32 restoring-division stages, output register
//  the 32 division stages, one quotient bit each, set the latency
//  reset clears valid bits and loads the identity matrix
//  a stalled output holds the pipeline only when its last stage is occupied
// ----------------------------------------------------------------------------
`default_nettype none

module homography_point_map_top
    import hpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // pixel_x, pixel_y

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // mapped_x, mapped_y
    output logic                       m_axis_tuser,   // bad_result

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [COEF_W-1:0]     pwdata,
    output logic [COEF_W-1:0]          prdata,
    output logic                       pready
);

    // configuration registers
    logic signed [COEF_W-1:0] coef_reg [NUM_REGS];
    hpm_reg_t                 cfg_idx;
    logic                     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = hpm_reg_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign prdata  = coef_reg[cfg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[REG_IDX_W'(i)] <= COEF_RESET[i];
            end
        end
        else if (cfg_wr)
        begin
            coef_reg[cfg_idx] <= pwdata;
        end
    end

    // flow control
    logic     out_vld_reg;
    logic     out_free;
    logic     adv;
    logic     div_vld  [QUOT_W+1];
    hpm_div_t div_pipe [QUOT_W+1];

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign adv           = out_free || !div_vld[QUOT_W];
    assign s_axis_tready = adv;

    // stage 1: six products
    logic [PIXEL_BITS-1:0]    pix_x;
    logic [PIXEL_BITS-1:0]    pix_y;
    logic signed [PIXEL_BITS:0] sx;
    logic signed [PIXEL_BITS:0] sy;
    logic                     v1_reg;
    logic signed [PROD_W-1:0] prod_reg  [6];
    logic signed [PROD_W-1:0] prod_next [6];

    assign pix_x = s_axis_tdata[PIXEL_BITS-1:0];
    assign pix_y = s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
    assign sx    = $signed({1'b0, pix_x});
    assign sy    = $signed({1'b0, pix_y});

    always_comb
    begin
        prod_next[0] = PROD_W'(coef_reg[REG_COEF_XX]) * PROD_W'(sx);
        prod_next[1] = PROD_W'(coef_reg[REG_COEF_XY]) * PROD_W'(sy);
        prod_next[2] = PROD_W'(coef_reg[REG_COEF_YX]) * PROD_W'(sx);
        prod_next[3] = PROD_W'(coef_reg[REG_COEF_YY]) * PROD_W'(sy);
        prod_next[4] = PROD_W'(coef_reg[REG_PERSP_X]) * PROD_W'(sx);
        prod_next[5] = PROD_W'(coef_reg[REG_PERSP_Y]) * PROD_W'(sy);
    end

    // stage 2: homogeneous sums
    logic                    v2_reg;
    logic signed [SUM_W-1:0] u_reg, v_reg, w_reg;
    logic signed [SUM_W-1:0] u_next, v_next, w_next;

    assign u_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                  + (SUM_W'(coef_reg[REG_COEF_XO]) <<< OFFSET_SHIFT);
    assign v_next = SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3])
                  + (SUM_W'(coef_reg[REG_COEF_YO]) <<< OFFSET_SHIFT);
    assign w_next = SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[5]) + W_ONE;

    // stage 3: magnitudes and signs
    logic             v3_reg;
    logic [MAG_W-1:0] mag_u_reg, mag_v_reg, mag_w_reg;
    logic [MAG_W-1:0] mag_u_next, mag_v_next, mag_w_next;
    logic             neg_u_reg, neg_v_reg, zero_u_reg, zero_v_reg;

    assign mag_u_next = MAG_W'(u_reg[SUM_W-1] ? -u_reg : u_reg);
    assign mag_v_next = MAG_W'(v_reg[SUM_W-1] ? -v_reg : v_reg);
    assign mag_w_next = MAG_W'(w_reg[SUM_W-1] ? -w_reg : w_reg);

    // stage 4: range check and divider setup
    hpm_div_t div_next;

    always_comb
    begin
        div_next.den     = mag_w_reg;
        div_next.lx.rem  = mag_u_reg >> FEED_W;
        div_next.lx.feed = mag_u_reg[FEED_W-1:0];
        div_next.lx.quo  = '0;
        div_next.lx.neg  = neg_u_reg;
        div_next.lx.sat  = ({2'b00, mag_u_reg} >= {mag_w_reg, 2'b00});
        div_next.lx.zero = zero_u_reg;
        div_next.ly.rem  = mag_v_reg >> FEED_W;
        div_next.ly.feed = mag_v_reg[FEED_W-1:0];
        div_next.ly.quo  = '0;
        div_next.ly.neg  = neg_v_reg;
        div_next.ly.sat  = ({2'b00, mag_v_reg} >= {mag_w_reg, 2'b00});
        div_next.ly.zero = zero_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            div_vld[0] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg     <= s_axis_tvalid;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            div_vld[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg    <= prod_next;
            u_reg       <= u_next;
            v_reg       <= v_next;
            w_reg       <= w_next;
            mag_u_reg   <= mag_u_next;
            mag_v_reg   <= mag_v_next;
            mag_w_reg   <= mag_w_next;
            neg_u_reg   <= u_reg[SUM_W-1] ^ w_reg[SUM_W-1];
            neg_v_reg   <= v_reg[SUM_W-1] ^ w_reg[SUM_W-1];
            zero_u_reg  <= (u_reg == '0);
            zero_v_reg  <= (v_reg == '0);
            div_pipe[0] <= div_next;
        end
    end

    // division stages
    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_div
        hpm_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_vld   (div_vld[k]),
            .in_item  (div_pipe[k]),
            .out_vld  (div_vld[k+1]),
            .out_item (div_pipe[k+1])
        );
    end

    // output register: sign, saturation, flag
    function automatic logic [QUOT_W:0] finish_lane(input hpm_lane_t l);
        logic              over;
        logic [QUOT_W-1:0] val;
        over = l.sat || (l.neg ? (l.quo > NEG_LIMIT) : l.quo[QUOT_W-1]);
        if (l.zero)
        begin
            val = '0;
        end
        else if (over)
        begin
            val = l.neg ? NEG_LIMIT : POS_LIMIT;
        end
        else
        begin
            val = l.neg ? -l.quo : l.quo;
        end
        return {over, val};
    endfunction

    logic [QUOT_W:0]     fin_x, fin_y;
    logic [QUOT_W-1:0]   map_x_reg, map_y_reg;
    logic                bad_reg;

    assign fin_x = finish_lane(div_pipe[QUOT_W].lx);
    assign fin_y = finish_lane(div_pipe[QUOT_W].ly);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= div_vld[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && div_vld[QUOT_W])
        begin
            map_x_reg <= fin_x[QUOT_W-1:0];
            map_y_reg <= fin_y[QUOT_W-1:0];
            bad_reg   <= fin_x[QUOT_W] | fin_y[QUOT_W];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {map_y_reg, map_x_reg};
    assign m_axis_tuser  = bad_reg;

    // checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready with empty output register");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready && div_vld[QUOT_W]) |-> !s_axis_tready)
        else $error("pipeline advanced into a stalled output");

    a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        (div_vld[QUOT_W] && !s_axis_tready) |=> div_vld[QUOT_W])
        else $error("item lost from last division stage during stall");

    a_zero_den_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (div_vld[0] && div_pipe[0].den == '0) |-> (div_pipe[0].lx.sat && div_pipe[0].ly.sat))
        else $error("zero divisor not flagged");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (div_vld[QUOT_W] && !div_pipe[QUOT_W].lx.sat)
            |-> (div_pipe[QUOT_W].lx.rem < div_pipe[QUOT_W].den))
        else $error("division remainder out of range");

endmodule

`default_nettype wire
